// ===== sv/tdt_pkg.sv =====
// Shared types and codes for the triplet dedup table.
package tdt_pkg;

  // Item kind codes
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Compare-swap step of the three-key sorting network
  typedef enum logic [1:0] {
    SORT_01_A,
    SORT_12,
    SORT_01_B
  } sort_step_t;

endpackage

// ===== sv/triplet_dedup_table.sv =====
// Triplet table: sort on one shared compare-swap unit, append and linear-scan lookup.
// Add: load, compare-swap sort steps and execute, then the result strobe; busy throughout.
// Query: an invalid triplet or an empty table ends after execute; else the table scan,
//   reading one entry per cycle, runs until a match or past the last entry.
// One item at a time; start is taken only while busy is low, also in the strobe cycle.
// Synchronous active-low reset empties the table (entry count to zero); no clearing pass.
module triplet_dedup_table
  import tdt_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int BUFFER_BITS = 4,
  parameter int INDEX_BITS  = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_kind,
  input  logic [BUFFER_BITS-1:0] in_buffer_a,
  input  logic [INDEX_BITS-1:0]  in_index_a,
  input  logic [BUFFER_BITS-1:0] in_buffer_b,
  input  logic [INDEX_BITS-1:0]  in_index_b,
  input  logic [BUFFER_BITS-1:0] in_buffer_c,
  input  logic [INDEX_BITS-1:0]  in_index_c,
  output logic                   out_valid,
  output logic                   out_found,
  output logic                   out_table_full
);

  localparam int KW = BUFFER_BITS + INDEX_BITS;
  localparam int EW = 3 * KW;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Control state
  state_t           state_r, state_nxt;
  sort_step_t       step_r, step_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    scan_addr_r, scan_addr_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic             out_full_r, out_full_nxt;

  // Item payload
  logic             kind_r, kind_nxt;
  logic [KW-1:0]    k0_r, k1_r, k2_r;
  logic [KW-1:0]    k0_nxt, k1_nxt, k2_nxt;

  // Table memory
  logic [EW-1:0]    mem [CAPACITY];
  logic [EW-1:0]    rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    rd_addr;

  // Shared compare-swap unit
  logic [KW-1:0]    cmp_lhs, cmp_rhs;
  logic             cmp_swap;

  // Validity terms on the sorted triplet
  logic db01, db12, di01, di12, di02, trip_ok;

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_table_full = out_full_r;
  assign rd_addr        = scan_addr_r[AW-1:0];

  // Operand select for the current sort step
  always_comb begin
    case (step_r)
      SORT_01_A: begin cmp_lhs = k0_r; cmp_rhs = k1_r; end
      SORT_12:   begin cmp_lhs = k1_r; cmp_rhs = k2_r; end
      SORT_01_B: begin cmp_lhs = k0_r; cmp_rhs = k1_r; end
      default:   begin cmp_lhs = k0_r; cmp_rhs = k1_r; end
    endcase
    cmp_swap = (cmp_lhs > cmp_rhs);
  end

  always_comb begin
    db01 = (k0_r[KW-1:INDEX_BITS] != k1_r[KW-1:INDEX_BITS]);
    db12 = (k1_r[KW-1:INDEX_BITS] != k2_r[KW-1:INDEX_BITS]);
    di01 = (k0_r[INDEX_BITS-1:0] != k1_r[INDEX_BITS-1:0]);
    di12 = (k1_r[INDEX_BITS-1:0] != k2_r[INDEX_BITS-1:0]);
    di02 = (k0_r[INDEX_BITS-1:0] != k2_r[INDEX_BITS-1:0]);
    trip_ok = (db01 && db12) || (db01 && di12) || (db12 && di01) ||
              (di01 && di12 && di02);
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    kind_nxt      = kind_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    k2_nxt        = k2_r;
    mem_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          k0_nxt    = {in_buffer_a, in_index_a};
          k1_nxt    = {in_buffer_b, in_index_b};
          k2_nxt    = {in_buffer_c, in_index_c};
          step_nxt  = SORT_01_A;
          state_nxt = ST_SORT;
        end
      end

      ST_SORT: begin
        case (step_r)
          SORT_12: begin
            if (cmp_swap) begin
              k1_nxt = k2_r;
              k2_nxt = k1_r;
            end
            step_nxt = SORT_01_B;
          end
          SORT_01_B: begin
            if (cmp_swap) begin
              k0_nxt = k1_r;
              k1_nxt = k0_r;
            end
            state_nxt = ST_EXEC;
          end
          default: begin
            if (cmp_swap) begin
              k0_nxt = k1_r;
              k1_nxt = k0_r;
            end
            step_nxt = SORT_12;
          end
        endcase
      end

      ST_EXEC: begin
        if (kind_r == KIND_ADD) begin
          out_found_nxt = 1'b0;
          if (count_r >= CW'(CAPACITY)) begin
            out_full_nxt = 1'b1;
          end else begin
            out_full_nxt = 1'b0;
            mem_we       = 1'b1;
            count_nxt    = count_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          out_full_nxt = 1'b0;
          if (!trip_ok) begin
            out_found_nxt = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (count_r == '0) begin
            out_found_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            scan_addr_nxt = '0;
            state_nxt     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the entry read the cycle before
        if (scan_addr_r < count_r) begin
          scan_addr_nxt = scan_addr_r + 1'b1;
          cmp_vld_nxt   = 1'b1;
        end
        if (cmp_vld_r && (rd_data_r == {k0_r, k1_r, k2_r})) begin
          out_found_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!cmp_vld_r && !(scan_addr_r < count_r)) begin
          out_found_nxt = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SORT_01_A;
      count_r     <= '0;
      scan_addr_r <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      out_full_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      scan_addr_r <= scan_addr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    k0_r   <= k0_nxt;
    k1_r   <= k1_nxt;
    k2_r   <= k2_nxt;
  end

  // Table memory: append at the fill count, registered read for the scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= {k0_r, k1_r, k2_r};
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== sim/tdt_checker.sv =====
// Scoreboard for the triplet dedup table: predicts each result and compares it.
module tdt_checker
  import tdt_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int BUFFER_BITS = 4,
  parameter int INDEX_BITS  = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   in_kind,
  input  logic [BUFFER_BITS-1:0] in_buffer_a,
  input  logic [INDEX_BITS-1:0]  in_index_a,
  input  logic [BUFFER_BITS-1:0] in_buffer_b,
  input  logic [INDEX_BITS-1:0]  in_index_b,
  input  logic [BUFFER_BITS-1:0] in_buffer_c,
  input  logic [INDEX_BITS-1:0]  in_index_c,
  input  logic                   out_valid,
  input  logic                   out_found,
  input  logic                   out_table_full,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KW = BUFFER_BITS + INDEX_BITS;

  // particle key: buffer id above index, so unsigned compare is lexicographic
  typedef logic [KW-1:0] pkey_t;

  typedef struct packed {
    logic found;
    logic table_full;
  } lookup_result_t;

  pkey_t          triplet_store [CAPACITY][3];
  int unsigned    stored_count;
  lookup_result_t lookup_q [$];

  // a sorted triplet is well formed unless two of its particles coincide
  function automatic bit triplet_valid(pkey_t a, pkey_t b, pkey_t c);
    bit diff_buf01;
    bit diff_buf12;
    bit diff_idx01;
    bit diff_idx12;
    bit diff_idx02;
    diff_buf01 = a[KW-1:INDEX_BITS] != b[KW-1:INDEX_BITS];
    diff_buf12 = b[KW-1:INDEX_BITS] != c[KW-1:INDEX_BITS];
    diff_idx01 = a[INDEX_BITS-1:0] != b[INDEX_BITS-1:0];
    diff_idx12 = b[INDEX_BITS-1:0] != c[INDEX_BITS-1:0];
    diff_idx02 = a[INDEX_BITS-1:0] != c[INDEX_BITS-1:0];
    return (diff_buf01 && diff_buf12) || (diff_buf01 && diff_idx12) ||
           (diff_buf12 && diff_idx01) || (diff_idx01 && diff_idx12 && diff_idx02);
  endfunction

  // sort the three keys, then append or look up; updates the shadow table
  function automatic lookup_result_t apply_item(logic kind, pkey_t k0, pkey_t k1, pkey_t k2);
    pkey_t          lo;
    pkey_t          mid;
    pkey_t          hi;
    pkey_t          tmp;
    lookup_result_t res;
    lo  = k0;
    mid = k1;
    hi  = k2;
    if (lo > mid) begin
      tmp = lo; lo = mid; mid = tmp;
    end
    if (mid > hi) begin
      tmp = mid; mid = hi; hi = tmp;
    end
    if (lo > mid) begin
      tmp = lo; lo = mid; mid = tmp;
    end
    res = '0;
    if (kind == KIND_ADD) begin
      if (stored_count >= CAPACITY) begin
        res.table_full = 1'b1;
      end else begin
        triplet_store[stored_count][0] = lo;
        triplet_store[stored_count][1] = mid;
        triplet_store[stored_count][2] = hi;
        stored_count++;
      end
    end else if (!triplet_valid(lo, mid, hi)) begin
      res.found = 1'b1;
    end else begin
      for (int n = 0; n < stored_count; n++) begin
        if (triplet_store[n][0] == lo && triplet_store[n][1] == mid &&
            triplet_store[n][2] == hi)
          res.found = 1'b1;
      end
    end
    return res;
  endfunction

  // results are retired before a new item is taken in the same cycle
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      stored_count = 0;
      lookup_q.delete();
    end else begin
      if (out_valid) begin
        if (lookup_q.size() == 0) begin
          $display("%0t: result with nothing pending: found %0b table_full %0b",
                   $time, out_found, out_table_full);
          fail_count++;
        end else begin
          want = lookup_q.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, out_found);
            fail_count++;
          end
          if (out_table_full !== want.table_full) begin
            $display("%0t: table_full mismatch, expected %0b actual %0b",
                     $time, want.table_full, out_table_full);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        lookup_q.insert(lookup_q.size(),
                        apply_item(in_kind, {in_buffer_a, in_index_a},
                                   {in_buffer_b, in_index_b},
                                   {in_buffer_c, in_index_c}));
    end
    pending <= lookup_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the triplet dedup table testbench: clock, reset, item stimulus and verdict.
module tb_top
  import tdt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 256;
  localparam int BUFFER_BITS = 4;
  localparam int INDEX_BITS  = 12;
  localparam int KW          = BUFFER_BITS + INDEX_BITS;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [BUFFER_BITS-1:0] buf_id;
    logic [INDEX_BITS-1:0]  idx;
  } particle_t;

  typedef particle_t [2:0] triplet_t;

  logic                   clk            = 1'b0;
  logic                   rst_n          = 1'b0;
  logic                   start          = 1'b0;
  logic                   in_kind        = 1'b0;
  logic [BUFFER_BITS-1:0] in_buffer_a    = '0;
  logic [INDEX_BITS-1:0]  in_index_a     = '0;
  logic [BUFFER_BITS-1:0] in_buffer_b    = '0;
  logic [INDEX_BITS-1:0]  in_index_b     = '0;
  logic [BUFFER_BITS-1:0] in_buffer_c    = '0;
  logic [INDEX_BITS-1:0]  in_index_c     = '0;
  logic                   busy;
  logic                   out_valid;
  logic                   out_found;
  logic                   out_table_full;
  int                     fail_count;
  int                     pending;

  triplet_t added_q [$];

  triplet_dedup_table #(
    .CAPACITY   (CAPACITY),
    .BUFFER_BITS(BUFFER_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_buffer_a   (in_buffer_a),
    .in_index_a    (in_index_a),
    .in_buffer_b   (in_buffer_b),
    .in_index_b    (in_index_b),
    .in_buffer_c   (in_buffer_c),
    .in_index_c    (in_index_c),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_table_full(out_table_full)
  );

  tdt_checker #(
    .CAPACITY   (CAPACITY),
    .BUFFER_BITS(BUFFER_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_buffer_a   (in_buffer_a),
    .in_index_a    (in_index_a),
    .in_buffer_b   (in_buffer_b),
    .in_index_b    (in_index_b),
    .in_buffer_c   (in_buffer_c),
    .in_index_c    (in_index_c),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_table_full(out_table_full),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog: too long without any item moving on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || out_valid)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic triplet_t mk(int b0, int i0, int b1, int i1, int b2, int i2);
    triplet_t t;
    t[0].buf_id = b0[BUFFER_BITS-1:0];
    t[0].idx    = i0[INDEX_BITS-1:0];
    t[1].buf_id = b1[BUFFER_BITS-1:0];
    t[1].idx    = i1[INDEX_BITS-1:0];
    t[2].buf_id = b2[BUFFER_BITS-1:0];
    t[2].idx    = i2[INDEX_BITS-1:0];
    return t;
  endfunction

  // narrow particles come from a tiny pool so that buffers and indices collide
  function automatic particle_t rand_particle(bit narrow);
    particle_t p;
    logic [31:0] r;
    r = $urandom();
    if (narrow) begin
      p.buf_id = BUFFER_BITS'($urandom_range(2));
      p.idx    = INDEX_BITS'($urandom_range(2));
    end else begin
      p.buf_id = r[BUFFER_BITS-1:0];
      p.idx    = r[INDEX_BITS+15:16];
    end
    return p;
  endfunction

  function automatic triplet_t shuffle(triplet_t t);
    particle_t tmp;
    int j;
    for (int n = 2; n > 0; n--) begin
      j    = $urandom_range(n);
      tmp  = t[n];
      t[n] = t[j];
      t[j] = tmp;
    end
    return t;
  endfunction

  function automatic triplet_t fresh_triplet();
    triplet_t t;
    bit narrow;
    narrow = $urandom_range(99) < 40;
    for (int n = 0; n < 3; n++)
      t[n] = rand_particle(narrow);
    return t;
  endfunction

  // two identical particles make a triplet malformed
  function automatic triplet_t degenerate_triplet();
    triplet_t t;
    bit narrow;
    narrow = $urandom_range(1);
    t[0] = rand_particle(narrow);
    t[1] = t[0];
    t[2] = rand_particle(narrow);
    return shuffle(t);
  endfunction

  function automatic triplet_t stored_pick();
    if (added_q.size() == 0)
      return fresh_triplet();
    return shuffle(added_q[$urandom_range(added_q.size() - 1)]);
  endfunction

  // random item: mostly adds and lookups of triplets already sent
  task automatic make_item(output logic kind, output triplet_t t);
    int pick;
    logic [3*KW-1:0] flip;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 45) begin
      kind = KIND_ADD;
      if (pick < 60)
        t = fresh_triplet();
      else if (pick < 80)
        t = stored_pick();
      else
        t = degenerate_triplet();
    end else begin
      kind = KIND_QUERY;
      if (pick < 40) begin
        t = stored_pick();
      end else if (pick < 55) begin
        // near miss: one bit off a stored triplet
        flip = '0;
        flip[$urandom_range(3*KW-1)] = 1'b1;
        t = triplet_t'(stored_pick() ^ flip);
      end else if (pick < 70) begin
        t = degenerate_triplet();
      end else begin
        t = fresh_triplet();
      end
    end
  endtask

  // present one item and hold it until the block takes it; start drops at random when gaps is set
  task automatic send(input logic kind, input triplet_t t, input bit gaps);
    bit taken;
    taken       = 1'b0;
    in_kind     <= kind;
    in_buffer_a <= t[0].buf_id;
    in_index_a  <= t[0].idx;
    in_buffer_b <= t[1].buf_id;
    in_index_b  <= t[1].idx;
    in_buffer_c <= t[2].buf_id;
    in_index_c  <= t[2].idx;
    if (kind == KIND_ADD)
      added_q.insert(added_q.size(), t);
    start <= !(gaps && $urandom_range(99) < 9);
    while (!taken) begin
      @(posedge clk);
      if (start && !busy)
        taken = 1'b1;
      else
        start <= !(gaps && $urandom_range(99) < 9);
    end
  endtask

  initial begin
    logic     kind;
    triplet_t t;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, field extremes, duplicates, each validity clause
    send(KIND_QUERY, mk(0, 0, 0, 0, 0, 0), 1'b0);
    send(KIND_QUERY, mk(1, 1, 2, 2, 3, 3), 1'b0);
    send(KIND_ADD,   mk(0, 0, 0, 0, 0, 0), 1'b1);
    send(KIND_ADD,   mk(15, 4095, 15, 4095, 15, 4095), 1'b1);
    send(KIND_ADD,   mk(15, 4095, 0, 0, 7, 2048), 1'b1);
    send(KIND_QUERY, mk(7, 2048, 15, 4095, 0, 0), 1'b1);
    send(KIND_QUERY, mk(0, 0, 7, 2048, 15, 4094), 1'b1);
    send(KIND_ADD,   mk(0, 0, 7, 2048, 15, 4095), 1'b1);
    send(KIND_QUERY, mk(15, 4095, 7, 2048, 0, 0), 1'b1);
    send(KIND_QUERY, mk(2, 5, 1, 5, 0, 5), 1'b1);
    send(KIND_ADD,   mk(0, 5, 1, 5, 2, 5), 1'b1);
    send(KIND_QUERY, mk(1, 5, 2, 5, 0, 5), 1'b1);
    send(KIND_QUERY, mk(1, 6, 0, 5, 1, 5), 1'b1);
    send(KIND_QUERY, mk(0, 5, 1, 5, 0, 6), 1'b1);
    send(KIND_ADD,   mk(3, 3, 3, 1, 3, 2), 1'b1);
    send(KIND_QUERY, mk(3, 1, 3, 2, 3, 3), 1'b1);
    send(KIND_QUERY, mk(3, 1, 3, 1, 3, 3), 1'b1);
    send(KIND_QUERY, mk(4, 9, 2, 9, 4, 9), 1'b1);
    send(KIND_QUERY, mk(15, 4095, 15, 4095, 15, 4095), 1'b1);
    send(KIND_QUERY, mk(15, 4095, 15, 0, 0, 4095), 1'b1);

    // random part; the table fills up about halfway through
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      make_item(kind, t);
      send(kind, t, !(n >= 400 && n < 800));
    end
    start <= 1'b0;

    // drain: pending is registered, so let it update before waiting for it to reach zero
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
